// ----- sv/lkv_pkg.sv -----
`default_nettype none

package lkv_pkg;

   // Number of slots in the store.
   localparam int DEPTH = 16;

   // Widths that follow from the depth.
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AGE_W = IDX_W;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Capacity register.
   localparam int CAP_W = 5;
   localparam int CAP_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Command codes.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // Value returned on a miss.
   localparam logic signed [31:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic               command;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   // One slot as seen by the scan.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic [AGE_W-1:0]   age;
   } entry_type;

   // Update of the store at the end of a scan.
   typedef struct packed {
      logic               en;
      logic               wr_data;
      logic               set_valid;
      logic               promote_all;
      logic [IDX_W-1:0]   idx;
      logic [AGE_W-1:0]   limit;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } update_type;

endpackage

`default_nettype wire

// ----- sv/lkv_store.sv -----
`default_nettype none

module lkv_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [lkv_pkg::IDX_W-1:0] rd_idx,
   output lkv_pkg::entry_type        rd_entry,
   input  wire lkv_pkg::update_type  upd,
   output logic [lkv_pkg::CNT_W-1:0] count
);
   import lkv_pkg::*;

   logic signed [31:0] key_ff   [DEPTH];
   logic signed [31:0] value_ff [DEPTH];
   logic [AGE_W-1:0]   age_ff   [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [CNT_W-1:0]   count_ff;

   // Read port for the scan, one slot a cycle.
   always_comb begin
      rd_entry.valid = valid_ff[rd_idx];
      rd_entry.key   = key_ff[rd_idx];
      rd_entry.value = value_ff[rd_idx];
      rd_entry.age   = age_ff[rd_idx];
   end

   assign count = count_ff;

   // Valid bits and fill count are cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (upd.en && upd.set_valid) begin
         valid_ff[upd.idx] <= 1'b1;
         count_ff          <= count_ff + 1'b1;
      end
   end

   // Key and value write, and the recency update of the valid slots.
   always_ff @(posedge clock) begin
      if (upd.en) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (valid_ff[i] && (IDX_W'(i) != upd.idx) &&
                (upd.promote_all || (age_ff[i] < upd.limit))) begin
               age_ff[i] <= age_ff[i] + 1'b1;
            end
         end
         age_ff[upd.idx] <= '0;
         if (upd.wr_data) begin
            key_ff[upd.idx]   <= upd.key;
            value_ff[upd.idx] <= upd.value;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/lkv_ctrl.sv -----
`default_nettype none

module lkv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire lkv_pkg::req_type     req_payload,
   output logic                      rsp_strobe,
   output lkv_pkg::rsp_type          rsp_payload,
   input  wire logic [lkv_pkg::CAP_W-1:0] capacity,
   output logic [lkv_pkg::IDX_W-1:0] rd_idx,
   input  wire lkv_pkg::entry_type   rd_entry,
   output lkv_pkg::update_type       upd,
   input  wire logic [lkv_pkg::CNT_W-1:0] count
);
   import lkv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cmd_ff;
   logic signed [31:0] key_ff, value_ff;

   logic               found_ff;
   logic [IDX_W-1:0]   found_idx_ff;
   logic [AGE_W-1:0]   found_age_ff;
   logic signed [31:0] found_value_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               victim_found_ff;
   logic [IDX_W-1:0]   victim_idx_ff;
   logic [AGE_W-1:0]   victim_age_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff;

   logic                 accept;
   logic                 scan_last;
   logic [CAP_CMP_W-1:0] cap_ext;
   logic [CAP_CMP_W-1:0] eff_cap;
   logic                 full;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign scan_last = (idx_ff == IDX_W'(DEPTH - 1));
   assign rd_idx    = idx_ff;

   // Effective capacity: zero counts as one, anything above the depth saturates.
   always_comb begin
      cap_ext = CAP_CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CAP_CMP_W'(1);
      end else if (cap_ext > CAP_CMP_W'(DEPTH)) begin
         eff_cap = CAP_CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
      full = (CAP_CMP_W'(count) >= eff_cap);
   end

   // Sequencer: one slot per cycle through the scan, then the update state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Request capture and the scan compare over the slot under the index.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         cmd_ff          <= req_payload.command;
         key_ff          <= req_payload.key;
         value_ff        <= req_payload.value;
         found_ff        <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (rd_entry.valid && (rd_entry.key == key_ff) && !found_ff) begin
            found_ff       <= 1'b1;
            found_idx_ff   <= idx_ff;
            found_age_ff   <= rd_entry.age;
            found_value_ff <= rd_entry.value;
         end
         if (!rd_entry.valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx_ff;
         end
         if (rd_entry.valid && (!victim_found_ff || (rd_entry.age > victim_age_ff))) begin
            victim_found_ff <= 1'b1;
            victim_idx_ff   <= idx_ff;
            victim_age_ff   <= rd_entry.age;
         end
      end
   end

   // Choice of the store update once the scan is complete.
   always_comb begin
      upd.en          = 1'b0;
      upd.wr_data     = 1'b0;
      upd.set_valid   = 1'b0;
      upd.promote_all = 1'b0;
      upd.idx         = found_idx_ff;
      upd.limit       = found_age_ff;
      upd.key         = key_ff;
      upd.value       = value_ff;
      if (state_ff == ST_UPDATE) begin
         if (found_ff) begin
            upd.en      = 1'b1;
            upd.wr_data = (cmd_ff == CMD_SET);
         end else if (cmd_ff == CMD_SET) begin
            if (full) begin
               upd.en      = victim_found_ff;
               upd.wr_data = 1'b1;
               upd.idx     = victim_idx_ff;
               upd.limit   = victim_age_ff;
            end else begin
               upd.en          = free_found_ff;
               upd.wr_data     = 1'b1;
               upd.set_valid   = 1'b1;
               upd.promote_all = 1'b1;
               upd.idx         = free_idx_ff;
            end
         end
      end
   end

   // Result register: a get gives one result in the cycle after its update.
   assign rsp_strobe_in = (state_ff == ST_UPDATE) && (cmd_ff == CMD_GET);

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_ff.hit        <= found_ff;
         rsp_ff.read_value <= found_ff ? found_value_ff : MISS_VALUE;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_after_get: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_UPDATE && cmd_ff == CMD_GET))
      else $error("result strobe without a get update");

   a_scan_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_last) |=> (state_ff == ST_UPDATE))
      else $error("scan end did not enter the update cycle");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("accepted request did not start a scan at slot zero");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      (upd.en && upd.set_valid) |-> (count < CNT_W'(DEPTH)))
      else $error("insert into a full store");

endmodule

`default_nettype wire

// ----- sv/lru_key_value_cache_top.sv -----
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Input channel: a request (command, key, value) is transferred at a rising
// edge with start high and busy low. A get returns one result; a set none.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_payload
// (hit flag and value, or -1 on a miss); the receiver cannot stall it.
// Configuration: csr_write_enable with csr_write_data writes the capacity
// register; write it only while busy is low and no result is pending.
// Sequence: a request keeps busy high through the scan and the update. The scan
// reads one slot per cycle through a single key and age compare over all DEPTH
// slots, then the update state writes the selected slot and steps the ages. The
// result strobe comes in the cycle after that update, the first cycle with busy
// low, so the next request can be transferred at the end of that cycle; a new
// request is not taken before the previous one has finished.
// Reset: synchronous and active high; clears all valid bits and the entry
// count, and sets the capacity to 16. No clearing pass is needed.
module lru_key_value_cache_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire lkv_pkg::req_type     req_payload,
   output logic                      rsp_strobe,
   output lkv_pkg::rsp_type          rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic [lkv_pkg::CAP_W-1:0] csr_write_data
);
   import lkv_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_entry;
   update_type       upd;
   logic [CNT_W-1:0] count;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   lkv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .capacity    (capacity_ff),
      .rd_idx      (rd_idx),
      .rd_entry    (rd_entry),
      .upd         (upd),
      .count       (count)
   );

   lkv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .upd      (upd),
      .count    (count)
   );

endmodule

`default_nettype wire
